// ----- rtl/core/pba_pkg.sv -----
// pba_pkg: shared types and codes for the page bitmap allocator
// request and result payload structs, request and status codes
// no dependencies
`default_nettype none

package pba_pkg;

    localparam int C_ADDR_W      = 32;
    localparam int C_PAGE_ADDR_W = 27;
    localparam int C_CFG_W       = 12;
    localparam int C_IDX_LIMIT   = 4096;
    localparam int C_PAGE_SHIFT  = 12;
    localparam int C_BYTE_SHIFT  = 15;

    localparam logic [7:0] C_FULL_BYTE = 8'hFF;

    localparam logic [1:0] REQ_INIT  = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_FREE  = 2'd2;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_NO_MEM    = 2'd1;
    localparam logic [1:0] STAT_UNALIGNED = 2'd2;

    typedef struct packed {
        logic [1:0]          req_type;
        logic [C_ADDR_W-1:0] free_address;
    } t_req;

    typedef struct packed {
        logic [1:0]               status;
        logic [C_PAGE_ADDR_W-1:0] page_address;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/core/pba_ram.sv -----
// pba_ram: generic single write port, single read port ram
// read data registered; no dependencies
`default_nettype none

module pba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ----- rtl/core/page_bitmap_allocator.sv -----
// page_bitmap_allocator: next-fit 4 KB page frame allocator over a used-page bitmap
// depends on pba_pkg (types, codes) and pba_ram (bitmap store)
//
// channel   direction  handshake                    payload
// request   in         start / busy                 i_req     (t_req)
// result    out        o_done strobe, one cycle     o_result  (t_result)
// config    in         i_cfg_valid / o_cfg_ready    i_cfg_data (bitmap_bytes)
//
// init sweeps bytes 0 to max(sentinel, reserved-1), one bitmap byte written per cycle;
//   alloc skips full bytes one at a time (single ram read port); free reads, then writes back
// rejected and no-op requests finish straight from idle; the result strobe is registered
// reset (synchronous, active low) clears control state and sets the search index;
//   bitmap contents are undefined until an init request
// results cannot be stalled; one request in flight, config taken only with none arriving
`default_nettype none

module page_bitmap_allocator
    import pba_pkg::*;
#(
    parameter int MAX_BITMAP_BYTES = 4096,
    parameter int RESERVED_BYTES   = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire t_req                i_req,
    output logic                     o_done,
    output t_result                  o_result,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [C_CFG_W-1:0]  i_cfg_data
);

    // bytes past the 12-bit search index range are never touched
    localparam int DEPTH = (MAX_BITMAP_BYTES < C_IDX_LIMIT) ? MAX_BITMAP_BYTES : C_IDX_LIMIT;
    localparam int AW    = $clog2(DEPTH);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_INIT  = 2'd1;
    localparam logic [1:0] S_ALLOC = 2'd2;
    localparam logic [1:0] S_FREE  = 2'd3;

    // position of the first clear bit, msb = lowest page
    function automatic logic [2:0] first_zero(input logic [7:0] b);
        logic [2:0] pos;
        pos = 3'd0;
        for (int i = 0; i < 8; i++) begin
            if (!b[i]) begin
                pos = 3'(7 - i);
            end
        end
        return pos;
    endfunction

    logic [1:0]         r_state, n_state;
    logic [AW-1:0]      r_idx, n_idx;
    logic [AW-1:0]      r_cnt, n_cnt;
    logic [AW-1:0]      r_fidx, n_fidx;
    logic [2:0]         r_fbit, n_fbit;
    logic [C_CFG_W-1:0] r_cfg;
    logic               r_done, n_done;
    t_result            r_result, n_result;

    logic          accept;
    logic [AW-1:0] sentinel;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;
    logic [2:0]    zbit;
    logic [16:0]   f_byte;
    logic          init_last;

    pba_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign busy        = (r_state != S_IDLE);
    assign accept      = start && !busy;
    assign o_cfg_ready = !busy && !start;
    assign o_done      = r_done;
    assign o_result    = r_result;

    // sentinel clamps to the last byte of the store
    assign sentinel = ({1'b0, r_cfg} >= (C_CFG_W+1)'(DEPTH)) ? AW'(DEPTH - 1)
                                                             : r_cfg[AW-1:0];

    assign zbit   = first_zero(rdata);
    assign f_byte = i_req.free_address[C_ADDR_W-1:C_BYTE_SHIFT];

    // sweep ends once both the sentinel and the reserved area are covered
    assign init_last = (r_cnt >= sentinel)
                    && (({1'b0, r_cnt} + (AW+1)'(1)) >= (AW+1)'(RESERVED_BYTES));

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_cnt    = r_cnt;
        n_fidx   = r_fidx;
        n_fbit   = r_fbit;
        n_done   = 1'b0;
        n_result = r_result;
        we       = 1'b0;
        waddr    = r_cnt;
        wdata    = 8'h00;
        raddr    = r_idx;

        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_result.status       = STAT_OK;
                    n_result.page_address = '0;
                    case (i_req.req_type)
                        REQ_INIT: begin
                            n_cnt   = '0;
                            n_state = S_INIT;
                        end
                        REQ_ALLOC: begin
                            raddr   = r_idx;
                            n_state = S_ALLOC;
                        end
                        REQ_FREE: begin
                            if (i_req.free_address[C_PAGE_SHIFT-1:0] != '0) begin
                                n_result.status = STAT_UNALIGNED;
                                n_done          = 1'b1;
                            end else if (f_byte >= 17'(sentinel)) begin
                                // beyond the bitmap: ignored
                                n_done = 1'b1;
                            end else begin
                                n_fidx  = f_byte[AW-1:0];
                                n_fbit  = i_req.free_address[C_BYTE_SHIFT-1:C_PAGE_SHIFT];
                                raddr   = f_byte[AW-1:0];
                                n_state = S_FREE;
                            end
                        end
                        default: begin
                            n_done = 1'b1;
                        end
                    endcase
                end
            end
            S_INIT: begin
                we    = 1'b1;
                waddr = r_cnt;
                wdata = (({1'b0, r_cnt} < (AW+1)'(RESERVED_BYTES)) || (r_cnt == sentinel))
                      ? C_FULL_BYTE : 8'h00;
                if (init_last) begin
                    n_idx   = AW'(RESERVED_BYTES);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_cnt = r_cnt + AW'(1);
                end
            end
            S_ALLOC: begin
                // rdata holds the byte at r_idx
                if (rdata == C_FULL_BYTE) begin
                    if (r_idx < sentinel) begin
                        n_idx = r_idx + AW'(1);
                        raddr = r_idx + AW'(1);
                    end else begin
                        n_result.status = STAT_NO_MEM;
                        n_done          = 1'b1;
                        n_state         = S_IDLE;
                    end
                end else begin
                    we    = 1'b1;
                    waddr = r_idx;
                    wdata = rdata | (8'h80 >> zbit);
                    n_result.page_address = (C_PAGE_ADDR_W'(r_idx) << C_BYTE_SHIFT)
                                          | (C_PAGE_ADDR_W'(zbit) << C_PAGE_SHIFT);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_FREE: begin
                we      = 1'b1;
                waddr   = r_fidx;
                wdata   = rdata & ~(8'h80 >> r_fbit);
                n_idx   = r_fidx;
                n_done  = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= AW'(RESERVED_BYTES);
            r_cfg   <= C_CFG_W'(4095);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    // payload and scratch registers
    always_ff @(posedge i_clk) begin
        r_cnt    <= n_cnt;
        r_fidx   <= n_fidx;
        r_fbit   <= n_fbit;
        r_result <= n_result;
    end

endmodule

`default_nettype wire
